/* src/sprite_rle_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Sprite RLE decoder assertion macros
// Shared assertion forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_RLE_DECODER_DEFINES_SVH
`define SPRITE_RLE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPRD_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPRD_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* src/sprd_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite RLE decoder package
// Widths, codes and the command and status types shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sprd_pkg;

   localparam int ADDR_BITS     = 20;
   localparam int OFFSET_BITS   = 20;
   localparam int PITCH_BITS    = 13;
   localparam int BYTE_BITS     = 8;
   localparam int CNT_BITS      = 6;
   localparam int HDR_BITS      = 3;
   localparam int HDR_LEN       = 6;
   localparam int PROD_BITS     = PITCH_BITS + BYTE_BITS;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int RSP_DATA_BITS = 32;

   localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(320);
   localparam logic [OFFSET_BITS-1:0] BASE_RESET = '0;

   localparam logic REG_LINE_PITCH  = 1'b0;
   localparam logic REG_BASE_OFFSET = 1'b1;

   localparam logic [1:0] OP_COPY = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_SKIP = 2'd2;
   localparam logic [1:0] OP_LINE = 2'd3;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_BASE,
      CUR_INC,
      CUR_ADD_CNT,
      CUR_ADD_BYTE,
      CUR_LINE_X
   } cursor_op_type;

   typedef struct packed {
      logic          load;
      cursor_op_type cursor_op;
      logic          line_add;
      logic          mul;
      logic          mul_byte;
      logic          emit;
      logic          emit_end;
      logic          emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic                start;
      logic [1:0]          op;
      logic [CNT_BITS-1:0] cnt;
      logic                byte_zero;
      logic                out_free;
   } dp_status_type;

endpackage

/* src/sprd_dp.sv */
// ----------------------------------------------------------------------------
// Sprite RLE decoder datapath
// Holds the current byte, write cursor, line start, pitch product and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sprd_pkg::dp_cmd_type                 cmd,
   output sprd_pkg::dp_status_type              status,
   input  logic [sprd_pkg::BYTE_BITS-1:0]       req_byte,
   input  logic                                 req_start,
   input  logic [sprd_pkg::PITCH_BITS-1:0]      line_pitch,
   input  logic [sprd_pkg::OFFSET_BITS-1:0]     base_offset,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sprd_pkg::OFFSET_BITS-1:0]     pixel_offset,
   output logic [sprd_pkg::BYTE_BITS-1:0]       pixel_value,
   output logic                                 kind,
   output logic                                 last
);

   logic [sprd_pkg::BYTE_BITS-1:0]   byte_ff,   byte_in;
   logic                             start_ff,  start_in;
   logic [sprd_pkg::ADDR_BITS-1:0]   cursor_ff, cursor_in;
   logic [sprd_pkg::ADDR_BITS-1:0]   line_ff,   line_in;
   logic [sprd_pkg::PROD_BITS-1:0]   prod_ff,   prod_in;
   logic                             valid_ff,  valid_in;
   logic [sprd_pkg::OFFSET_BITS-1:0] off_ff,    off_in;
   logic [sprd_pkg::BYTE_BITS-1:0]   val_ff,    val_in;
   logic                             kind_ff,   kind_in;
   logic                             last_ff,   last_in;
   logic [sprd_pkg::BYTE_BITS-1:0]   mul_operand;
   logic                             out_free;

   assign out_free = !valid_ff || rsp_tready;

   assign status.start     = start_ff;
   assign status.op        = byte_ff[sprd_pkg::BYTE_BITS-1 -: 2];
   assign status.cnt       = byte_ff[sprd_pkg::CNT_BITS-1:0];
   assign status.byte_zero = (byte_ff == '0);
   assign status.out_free  = out_free;

   always_comb begin
      byte_in  = cmd.load ? req_byte : byte_ff;
      start_in = cmd.load ? req_start : start_ff;

      case (cmd.cursor_op)
         sprd_pkg::CUR_BASE:     cursor_in = sprd_pkg::ADDR_BITS'(base_offset);
         sprd_pkg::CUR_INC:      cursor_in = cursor_ff + sprd_pkg::ADDR_BITS'(1);
         sprd_pkg::CUR_ADD_CNT:  cursor_in = cursor_ff
                                     + sprd_pkg::ADDR_BITS'(byte_ff[sprd_pkg::CNT_BITS-1:0]);
         sprd_pkg::CUR_ADD_BYTE: cursor_in = cursor_ff + sprd_pkg::ADDR_BITS'(byte_ff);
         sprd_pkg::CUR_LINE_X:   cursor_in = line_ff + sprd_pkg::ADDR_BITS'(byte_ff);
         default:                cursor_in = cursor_ff;
      endcase

      if (cmd.cursor_op == sprd_pkg::CUR_BASE) begin
         line_in = sprd_pkg::ADDR_BITS'(base_offset);
      end else if (cmd.line_add) begin
         line_in = line_ff + sprd_pkg::ADDR_BITS'(prod_ff);
      end else begin
         line_in = line_ff;
      end

      mul_operand = cmd.mul_byte ? byte_ff
                                 : sprd_pkg::BYTE_BITS'(byte_ff[sprd_pkg::CNT_BITS-1:0]);
      prod_in = cmd.mul ? sprd_pkg::PROD_BITS'(line_pitch) * sprd_pkg::PROD_BITS'(mul_operand)
                        : prod_ff;

      valid_in = valid_ff;
      off_in   = off_ff;
      val_in   = val_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         off_in   = cmd.emit_end ? '0 : sprd_pkg::OFFSET_BITS'(cursor_ff);
         val_in   = cmd.emit_end ? '0 : byte_ff;
         kind_in  = cmd.emit_end;
         last_in  = cmd.emit_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         line_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         line_ff   <= line_in;
         valid_ff  <= valid_in;
      end
      byte_ff  <= byte_in;
      start_ff <= start_in;
      prod_ff  <= prod_in;
      off_ff   <= off_in;
      val_ff   <= val_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign pixel_offset = off_ff;
   assign pixel_value  = val_ff;
   assign kind         = kind_ff;
   assign last         = last_ff;

endmodule

/* src/sprd_ctrl.sv */
// ----------------------------------------------------------------------------
// Sprite RLE decoder controller
// Tracks the decode phase, header and run counters, and steps the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sprite_rle_decoder_defines.svh"

module sprd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sprd_pkg::dp_status_type status,
   output sprd_pkg::dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_ADDLINE
   } step_type;

   typedef enum logic [2:0] {
      PH_FINISHED,
      PH_HEADER,
      PH_CODE,
      PH_COPY,
      PH_FILLVAL,
      PH_SKIPCNT,
      PH_LINECNT,
      PH_XOFF
   } phase_type;

   step_type                          step_ff,  step_in;
   phase_type                         phase_ff, phase_in;
   logic [sprd_pkg::HDR_BITS-1:0]     hdr_ff,   hdr_in;
   logic [sprd_pkg::CNT_BITS-1:0]     run_ff,   run_in;
   logic                              run_one;

   assign req_tready = (step_ff == ST_IDLE);
   assign run_one    = (run_ff == sprd_pkg::CNT_BITS'(1));

   always_comb begin
      step_in  = step_ff;
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      run_in   = run_ff;
      cmd      = '0;

      unique case (step_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            step_in = ST_IDLE;
            if (status.start) begin
               cmd.cursor_op = sprd_pkg::CUR_BASE;
               run_in        = '0;
               hdr_in        = sprd_pkg::HDR_BITS'(sprd_pkg::HDR_LEN - 1);
               phase_in      = PH_HEADER;
            end else begin
               unique case (phase_ff)
                  PH_FINISHED: begin
                  end
                  PH_HEADER: begin
                     hdr_in = hdr_ff - sprd_pkg::HDR_BITS'(1);
                     if (hdr_ff == sprd_pkg::HDR_BITS'(1)) begin
                        phase_in = PH_CODE;
                     end
                  end
                  PH_CODE: begin
                     unique case (status.op)
                        sprd_pkg::OP_COPY: begin
                           run_in = status.cnt;
                           if (status.cnt != '0) begin
                              phase_in = PH_COPY;
                           end
                        end
                        sprd_pkg::OP_FILL: begin
                           run_in   = status.cnt;
                           phase_in = PH_FILLVAL;
                        end
                        sprd_pkg::OP_SKIP: begin
                           if (status.cnt == '0) begin
                              phase_in = PH_SKIPCNT;
                           end else begin
                              cmd.cursor_op = sprd_pkg::CUR_ADD_CNT;
                           end
                        end
                        sprd_pkg::OP_LINE: begin
                           if (status.cnt == '0) begin
                              phase_in = PH_LINECNT;
                           end else begin
                              cmd.mul  = 1'b1;
                              phase_in = PH_XOFF;
                              step_in  = ST_ADDLINE;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  PH_COPY: begin
                     if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.cursor_op = sprd_pkg::CUR_INC;
                        run_in        = run_ff - sprd_pkg::CNT_BITS'(1);
                        if (run_one) begin
                           phase_in = PH_CODE;
                        end
                     end else begin
                        step_in = ST_DECODE;
                     end
                  end
                  PH_FILLVAL: begin
                     if (run_ff == '0) begin
                        phase_in = PH_CODE;
                     end else begin
                        step_in = ST_FILL;
                     end
                  end
                  PH_SKIPCNT: begin
                     cmd.cursor_op = sprd_pkg::CUR_ADD_BYTE;
                     phase_in      = PH_CODE;
                  end
                  PH_LINECNT: begin
                     if (status.byte_zero) begin
                        if (status.out_free) begin
                           cmd.emit      = 1'b1;
                           cmd.emit_end  = 1'b1;
                           cmd.emit_last = 1'b1;
                           phase_in      = PH_FINISHED;
                        end else begin
                           step_in = ST_DECODE;
                        end
                     end else begin
                        cmd.mul      = 1'b1;
                        cmd.mul_byte = 1'b1;
                        phase_in     = PH_XOFF;
                        step_in      = ST_ADDLINE;
                     end
                  end
                  PH_XOFF: begin
                     cmd.cursor_op = sprd_pkg::CUR_LINE_X;
                     phase_in      = PH_CODE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = run_one;
               cmd.cursor_op = sprd_pkg::CUR_INC;
               run_in        = run_ff - sprd_pkg::CNT_BITS'(1);
               if (run_one) begin
                  phase_in = PH_CODE;
                  step_in  = ST_IDLE;
               end
            end
         end
         ST_ADDLINE: begin
            cmd.line_add = 1'b1;
            step_in      = ST_IDLE;
         end
         default: begin
            step_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         phase_ff <= PH_FINISHED;
         hdr_ff   <= '0;
         run_ff   <= '0;
      end else begin
         step_ff  <= step_in;
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         run_ff   <= run_in;
      end
   end

   `SPRD_ASSERT_NOW(a_emit_when_free, cmd.emit, status.out_free,
      "result emitted while the result register is still full")
   `SPRD_ASSERT_NOW(a_fill_run_nonzero, step_ff == ST_FILL, run_ff != '0,
      "fill step entered with an empty run")
   `SPRD_ASSERT_NEXT(a_accept_decodes, req_tvalid && req_tready, step_ff == ST_DECODE,
      "accepted item was not decoded in the next cycle")
   `SPRD_ASSERT_NOW(a_header_count, phase_ff == PH_HEADER, hdr_ff != '0,
      "header phase with no header bytes left")

endmodule

/* src/sprite_rle_decoder.sv */
// ----------------------------------------------------------------------------
// Sprite RLE decoder
// Decodes a run-length coded sprite byte stream into pixel writes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  req_      in         tdata: byte_value; tuser: start_req
//  rsp_      out        tdata: pixel_offset, pixel_value; tuser: kind; tlast: last
//  csr_      in         APB writes/reads of line_pitch (0x0) and base_offset (0x4)
//
//  Each input item is accepted in the idle step and then decoded in the decode step.
//  A fill value item then emits its count of pixels from the fill step, stalling on a full result.
//  A line advance goes on to the add-line step, for the registered pitch multiplication.
//  Reset is synchronous and returns the decoder to the finished phase.
//  A full result register holds the decoder in its emitting step until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_rle_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sprd_pkg::BYTE_BITS-1:0]       req_tdata,  // [7:0] byte_value
   input  logic                                 req_tuser,  // [0] start_req
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sprd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // [19:0] pixel_offset, [27:20] pixel_value
   output logic                                 rsp_tuser,  // [0] kind
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sprd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [sprd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [sprd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   logic [sprd_pkg::PITCH_BITS-1:0]  pitch_ff, pitch_in;
   logic [sprd_pkg::OFFSET_BITS-1:0] base_ff,  base_in;
   logic                             csr_write;
   logic                             reg_sel;
   sprd_pkg::dp_cmd_type             cmd;
   sprd_pkg::dp_status_type          status;
   logic [sprd_pkg::OFFSET_BITS-1:0] pixel_offset;
   logic [sprd_pkg::BYTE_BITS-1:0]   pixel_value;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      pitch_in = pitch_ff;
      base_in  = base_ff;
      if (csr_write) begin
         unique case (reg_sel)
            sprd_pkg::REG_LINE_PITCH:  pitch_in = csr_pwdata[sprd_pkg::PITCH_BITS-1:0];
            sprd_pkg::REG_BASE_OFFSET: base_in  = csr_pwdata[sprd_pkg::OFFSET_BITS-1:0];
            default: begin
            end
         endcase
      end
      unique case (reg_sel)
         sprd_pkg::REG_LINE_PITCH:  csr_prdata = sprd_pkg::CSR_DATA_BITS'(pitch_ff);
         sprd_pkg::REG_BASE_OFFSET: csr_prdata = sprd_pkg::CSR_DATA_BITS'(base_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= sprd_pkg::PITCH_RESET;
         base_ff  <= sprd_pkg::BASE_RESET;
      end else begin
         pitch_ff <= pitch_in;
         base_ff  <= base_in;
      end
   end

   sprd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sprd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_byte     (req_tdata),
      .req_start    (req_tuser),
      .line_pitch   (pitch_ff),
      .base_offset  (base_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .pixel_offset (pixel_offset),
      .pixel_value  (pixel_value),
      .kind         (rsp_tuser),
      .last         (rsp_tlast)
   );

   assign rsp_tdata = {{(sprd_pkg::RSP_DATA_BITS - sprd_pkg::OFFSET_BITS
                         - sprd_pkg::BYTE_BITS){1'b0}}, pixel_value, pixel_offset};

endmodule

/* dv/sprite_rle_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Sprite RLE decoder testbench
// Feeds compressed sprite byte streams into the decoder and checks every pixel
// write and end-of-sprite marker against a cycle-free model of the decoder.
// The sender idles in random bursts while the receiver stalls on its own
// pattern. Both registers are written and read back between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_rle_decoder_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS = 20;

   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_HEADER,
      DEC_CODE,
      DEC_COPY,
      DEC_FILL_VALUE,
      DEC_SKIP_COUNT,
      DEC_LINE_COUNT,
      DEC_X_OFFSET
   } dec_phase_type;

   typedef enum int {
      RX_STREAM,
      RX_RANDOM,
      RX_EVERY_THIRD,
      RX_SPARSE
   } rx_pattern_type;

   typedef struct packed {
      logic [sprd_pkg::OFFSET_BITS-1:0] offset;
      logic [sprd_pkg::BYTE_BITS-1:0]   value;
      logic                             kind;
      logic                             last;
   } pixel_write_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [sprd_pkg::BYTE_BITS-1:0]      req_tdata = '0;    // [7:0] byte_value
   logic                                req_tuser = 1'b0;  // [0] start_req
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [sprd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;  // [19:0] pixel_offset, [27:20] pixel_value
   logic                                rsp_tuser;  // [0] kind
   logic                                rsp_tlast;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [sprd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [sprd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [sprd_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                csr_pready;

   dec_phase_type                       dec_phase = DEC_IDLE;
   logic [sprd_pkg::HDR_BITS-1:0]       hdr_remaining = '0;
   logic [sprd_pkg::CNT_BITS-1:0]       run_remaining = '0;
   logic [sprd_pkg::ADDR_BITS-1:0]      pen_addr = '0;
   logic [sprd_pkg::ADDR_BITS-1:0]      row_addr = '0;
   logic [sprd_pkg::PITCH_BITS-1:0]     pitch_setting = sprd_pkg::PITCH_RESET;
   logic [sprd_pkg::OFFSET_BITS-1:0]    base_setting = sprd_pkg::BASE_RESET;

   pixel_write_type                     pixel_writes_due [$];
   pixel_write_type                     due_write;
   int                                  error_count = 0;
   int                                  bytes_sent = 0;
   int                                  burst_left = 0;
   int                                  cycle_count = 0;
   rx_pattern_type                      rx_pattern = RX_STREAM;
   int                                  rx_pattern_cycles = 0;
   int                                  rx_tick = 0;

   sprite_rle_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void note_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic pixel_write_type make_write(
         input logic [sprd_pkg::ADDR_BITS-1:0] addr,
         input logic [sprd_pkg::BYTE_BITS-1:0] value,
         input logic kind, input logic last);
      pixel_write_type w;
      w.offset = sprd_pkg::OFFSET_BITS'(addr);
      w.value = value;
      w.kind = kind;
      w.last = last;
      return w;
   endfunction

   // Advances the decoder model by one accepted item and queues the writes it causes.
   function automatic void decode_byte(input logic [sprd_pkg::BYTE_BITS-1:0] data,
                                       input logic start);
      logic [sprd_pkg::PROD_BITS-1:0] row_step;
      logic [sprd_pkg::CNT_BITS-1:0]  count;
      count = data[sprd_pkg::CNT_BITS-1:0];
      if (start) begin
         pen_addr = sprd_pkg::ADDR_BITS'(base_setting);
         row_addr = sprd_pkg::ADDR_BITS'(base_setting);
         run_remaining = '0;
         hdr_remaining = sprd_pkg::HDR_BITS'(sprd_pkg::HDR_LEN - 1);
         dec_phase = DEC_HEADER;
         return;
      end
      case (dec_phase)
         DEC_HEADER: begin
            hdr_remaining = hdr_remaining - sprd_pkg::HDR_BITS'(1);
            if (hdr_remaining == '0) dec_phase = DEC_CODE;
         end
         DEC_CODE: begin
            case (data[7:6])
               sprd_pkg::OP_COPY: begin
                  run_remaining = count;
                  if (count != '0) dec_phase = DEC_COPY;
               end
               sprd_pkg::OP_FILL: begin
                  run_remaining = count;
                  dec_phase = DEC_FILL_VALUE;
               end
               sprd_pkg::OP_SKIP: begin
                  if (count == '0) dec_phase = DEC_SKIP_COUNT;
                  else pen_addr = pen_addr + sprd_pkg::ADDR_BITS'(count);
               end
               default: begin
                  if (count == '0) begin
                     dec_phase = DEC_LINE_COUNT;
                  end else begin
                     row_step = sprd_pkg::PROD_BITS'(pitch_setting)
                                * sprd_pkg::PROD_BITS'(count);
                     row_addr = row_addr + sprd_pkg::ADDR_BITS'(row_step);
                     dec_phase = DEC_X_OFFSET;
                  end
               end
            endcase
         end
         DEC_COPY: begin
            pixel_writes_due.push_back(make_write(pen_addr, data, 1'b0, 1'b1));
            pen_addr = pen_addr + sprd_pkg::ADDR_BITS'(1);
            run_remaining = run_remaining - sprd_pkg::CNT_BITS'(1);
            if (run_remaining == '0) dec_phase = DEC_CODE;
         end
         DEC_FILL_VALUE: begin
            for (int i = 0; i < int'(run_remaining); i++) begin
               pixel_writes_due.push_back(make_write(pen_addr, data, 1'b0,
                                                     i == int'(run_remaining) - 1));
               pen_addr = pen_addr + sprd_pkg::ADDR_BITS'(1);
            end
            run_remaining = '0;
            dec_phase = DEC_CODE;
         end
         DEC_SKIP_COUNT: begin
            pen_addr = pen_addr + sprd_pkg::ADDR_BITS'(data);
            dec_phase = DEC_CODE;
         end
         DEC_LINE_COUNT: begin
            if (data == '0) begin
               pixel_writes_due.push_back(make_write('0, '0, 1'b1, 1'b1));
               dec_phase = DEC_IDLE;
            end else begin
               row_step = sprd_pkg::PROD_BITS'(pitch_setting) * sprd_pkg::PROD_BITS'(data);
               row_addr = row_addr + sprd_pkg::ADDR_BITS'(row_step);
               dec_phase = DEC_X_OFFSET;
            end
         end
         DEC_X_OFFSET: begin
            pen_addr = row_addr + sprd_pkg::ADDR_BITS'(data);
            dec_phase = DEC_CODE;
         end
         default: ;
      endcase
   endfunction

   task automatic send_byte(input logic [sprd_pkg::BYTE_BITS-1:0] data, input logic start);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(data, start);
      bytes_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pixel_writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index,
                                 input logic [sprd_pkg::CSR_DATA_BITS-1:0] data);
      logic [sprd_pkg::CSR_DATA_BITS-1:0] readback;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (index == sprd_pkg::REG_LINE_PITCH) begin
         pitch_setting = data[sprd_pkg::PITCH_BITS-1:0];
         readback = sprd_pkg::CSR_DATA_BITS'(pitch_setting);
      end else begin
         base_setting = data[sprd_pkg::OFFSET_BITS-1:0];
         readback = sprd_pkg::CSR_DATA_BITS'(base_setting);
      end
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== readback) begin
         note_mismatch($sformatf("register %0d read back %h, expected %h",
                                 index, csr_prdata, readback));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One sprite, mostly well formed, sometimes restarted or abandoned midway.
   task automatic make_sprite();
      int n_ops;
      int choice;
      int count;
      send_byte(8'($urandom), 1'b1);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
         send_byte(8'($urandom), 1'b1);
      end
      repeat (sprd_pkg::HDR_LEN - 1) send_byte(8'($urandom), 1'b0);
      n_ops = $urandom_range(2, 8);
      repeat (n_ops) begin
         choice = $urandom_range(0, 9);
         if (choice < 3) begin
            count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            send_byte({sprd_pkg::OP_COPY, sprd_pkg::CNT_BITS'(count)}, 1'b0);
            repeat (count) send_byte(8'($urandom), 1'b0);
         end else if (choice < 5) begin
            choice = $urandom_range(0, 9);
            count = (choice == 0) ? 63 : (choice == 1) ? 0 : $urandom_range(1, 16);
            send_byte({sprd_pkg::OP_FILL, sprd_pkg::CNT_BITS'(count)}, 1'b0);
            send_byte(8'($urandom), 1'b0);
         end else if (choice < 7) begin
            count = $urandom_range(0, 63);
            send_byte({sprd_pkg::OP_SKIP, sprd_pkg::CNT_BITS'(count)}, 1'b0);
            if (count == 0) send_byte(8'($urandom), 1'b0);
         end else if (choice < 9) begin
            if ($urandom_range(0, 1) == 0) begin
               send_byte({sprd_pkg::OP_LINE, sprd_pkg::CNT_BITS'($urandom_range(1, 63))},
                         1'b0);
            end else begin
               send_byte({sprd_pkg::OP_LINE, sprd_pkg::CNT_BITS'(0)}, 1'b0);
               send_byte(8'($urandom_range(1, 255)), 1'b0);
            end
            send_byte(8'($urandom), 1'b0);
         end else begin
            send_byte(8'($urandom), 1'b0);
         end
      end
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
         send_byte({sprd_pkg::OP_LINE, sprd_pkg::CNT_BITS'(0)}, 1'b0);
         send_byte(8'd0, 1'b0);
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
      end else if (choice == 9) begin
         send_byte(8'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_directed_ops();
      send_byte(8'h5A, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte({sprd_pkg::OP_COPY, sprd_pkg::CNT_BITS'(2)}, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte({sprd_pkg::OP_FILL, sprd_pkg::CNT_BITS'(0)}, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte({sprd_pkg::OP_COPY, sprd_pkg::CNT_BITS'(0)}, 1'b0);
      send_byte({sprd_pkg::OP_FILL, sprd_pkg::CNT_BITS'(63)}, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte({sprd_pkg::OP_SKIP, sprd_pkg::CNT_BITS'(5)}, 1'b0);
      send_byte({sprd_pkg::OP_SKIP, sprd_pkg::CNT_BITS'(0)}, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte({sprd_pkg::OP_LINE, sprd_pkg::CNT_BITS'(2)}, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte({sprd_pkg::OP_LINE, sprd_pkg::CNT_BITS'(0)}, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte({sprd_pkg::OP_LINE, sprd_pkg::CNT_BITS'(0)}, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      settle();
   endtask

   task automatic test_random_sprites();
      logic [sprd_pkg::PITCH_BITS-1:0]  pitch;
      logic [sprd_pkg::OFFSET_BITS-1:0] base;
      int                               phase_start;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               pitch = sprd_pkg::PITCH_BITS'(1);
               base = '1;
            end
            1: begin
               pitch = '1;
               base = sprd_pkg::OFFSET_BITS'(20'hFFF00);
            end
            2: begin
               pitch = '0;
               base = sprd_pkg::OFFSET_BITS'($urandom);
            end
            3: begin
               pitch = sprd_pkg::PITCH_BITS'(4096);
               base = '0;
            end
            default: begin
               pitch = sprd_pkg::PITCH_BITS'($urandom_range(1, 4096));
               base = sprd_pkg::OFFSET_BITS'($urandom);
            end
         endcase
         write_register(sprd_pkg::REG_LINE_PITCH, sprd_pkg::CSR_DATA_BITS'(pitch));
         write_register(sprd_pkg::REG_BASE_OFFSET, sprd_pkg::CSR_DATA_BITS'(base));
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_ITEMS) make_sprite();
         settle();
      end
   endtask

   always @(negedge clock) begin
      if (rx_pattern_cycles == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_pattern_cycles = $urandom_range(16, 80);
      end else begin
         rx_pattern_cycles--;
      end
      rx_tick++;
      case (rx_pattern)
         RX_STREAM:      rsp_tready <= 1'b1;
         RX_RANDOM:      rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_EVERY_THIRD: rsp_tready <= (rx_tick % 3 == 0);
         default:        rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_writes_due.size() == 0) begin
            note_mismatch($sformatf("unexpected item: tdata %h kind %b last %b",
                                    rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            due_write = pixel_writes_due.pop_front();
            if (rsp_tdata[19:0] !== due_write.offset ||
                rsp_tdata[27:20] !== due_write.value ||
                rsp_tdata[31:28] !== 4'h0 ||
                rsp_tuser !== due_write.kind ||
                rsp_tlast !== due_write.last) begin
               note_mismatch($sformatf(
                  "item mismatch: offset %h/%h value %h/%h kind %b/%b last %b/%b pad %h",
                  rsp_tdata[19:0], due_write.offset, rsp_tdata[27:20], due_write.value,
                  rsp_tuser, due_write.kind, rsp_tlast, due_write.last,
                  rsp_tdata[31:28]));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sprite_rle_decoder test failed");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_random_sprites();
      settle();
      if (error_count == 0 && pixel_writes_due.size() == 0) begin
         $display("sprite_rle_decoder test passed");
      end else begin
         $display("sprite_rle_decoder test failed");
      end
      $finish;
   end

endmodule
